// ----- hdl/bia_pkg.sv -----
// types and constants shared by the bitmap id allocator files
`default_nettype none

package bia_pkg;

   // fixed field widths
   localparam int ID_W       = 13;
   localparam int NODE_W     = 16;
   localparam int FW_W       = 8;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // configuration reset values
   localparam logic [FW_W-1:0]   FIRST_WORD_RESET = 8'd1;
   localparam logic [NODE_W-1:0] OWN_NODE_RESET   = 16'd0;

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_WORD = 1'b0,
      CSR_OWN_NODE   = 1'b1
   } csr_index_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 2'd0,
      STAT_EXHAUSTED   = 2'd1,
      STAT_DOUBLE_FREE = 2'd2,
      STAT_FOREIGN     = 2'd3
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_ASRCH,
      ST_FREM,
      ST_FCHK,
      ST_PSRCH,
      ST_DONE
   } bia_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic init_wr;
      logic accept;
      logic srch_step;
      logic alloc_take;
      logic alloc_fail;
      logic rover_set;
      logic free_decode;
      logic free_set;
      logic free_dup;
      logic load_out;
   } bia_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic init_last;
      logic word_nonzero;
      logic search_last;
      logic cleared_nonzero;
      logic foreign;
      logic in_range;
      logic bit_set;
      logic on_rover;
      logic out_free;
   } bia_stat_type;

endpackage

`default_nettype wire

// ----- hdl/bia_if.sv -----
// request and response channel interfaces of the bitmap id allocator
`default_nettype none

interface bia_req_if import bia_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [NODE_W-1:0] free_node;
   logic [ID_W-1:0]   free_id;

   modport source (output valid, kind, free_node, free_id, input ready);
   modport sink   (input valid, kind, free_node, free_id, output ready);
endinterface

interface bia_rsp_if import bia_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     ident;
   logic [STATUS_W-1:0] status;

   modport source (output valid, ident, status, input ready);
   modport sink   (input valid, ident, status, output ready);
endinterface

`default_nettype wire

// ----- hdl/bia_ctrl.sv -----
// controller state machine of the bitmap id allocator
`default_nettype none

module bia_ctrl import bia_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_kind,
   output logic              req_ready,
   input  wire bia_stat_type stat,
   output bia_cmd_type       cmd
);

   bia_state_type state_ff;
   bia_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            // fill the map with all-free words
            cmd.init_wr = 1'b1;
            if (stat.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_kind == KIND_ALLOC) ? ST_ASRCH : ST_FREM;
            end
         end
         ST_ASRCH: begin
            // look for a word with a free bit, starting at the rover
            if (stat.word_nonzero) begin
               cmd.alloc_take = 1'b1;
               state_in       = stat.cleared_nonzero ? ST_DONE : ST_PSRCH;
            end else if (stat.search_last) begin
               cmd.alloc_fail = 1'b1;
               state_in       = ST_DONE;
            end else begin
               cmd.srch_step = 1'b1;
            end
         end
         ST_FREM: begin
            cmd.free_decode = 1'b1;
            if (stat.foreign || !stat.in_range) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_FCHK;
            end
         end
         ST_FCHK: begin
            if (stat.bit_set) begin
               cmd.free_dup = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.free_set = 1'b1;
               state_in     = stat.on_rover ? ST_PSRCH : ST_DONE;
            end
         end
         ST_PSRCH: begin
            // move the rover on to the next word with a free bit
            if (stat.word_nonzero) begin
               cmd.rover_set = 1'b1;
               state_in      = ST_DONE;
            end else if (stat.search_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.srch_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/bia_datapath.sv -----
// bitmap memory, rover, free-id decode and result registers of the allocator
`default_nettype none

module bia_datapath import bia_pkg::*; #(
   parameter int MAP_WORDS = 256,
   parameter int WORD_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [NODE_W-1:0]     req_free_node,
   input  wire logic [ID_W-1:0]       req_free_id,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [ID_W-1:0]            rsp_ident,
   output logic [STATUS_W-1:0]        rsp_status,
   input  wire bia_cmd_type           cmd,
   output bia_stat_type               stat
);

   localparam int AW = $clog2(MAP_WORDS);
   localparam int BW = $clog2(WORD_BITS);
   localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
   // reciprocal for the word index of a free id
   localparam int DIV_SH    = ID_W + BW;
   localparam int DIV_MUL_W = DIV_SH + 1;
   localparam int PROD_W    = ID_W + DIV_MUL_W;
   localparam logic [DIV_MUL_W-1:0] DIV_MUL =
      DIV_MUL_W'(((64'd1 << DIV_SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
   localparam logic [WORD_BITS-1:0] WORD_ONE = WORD_BITS'(1);

   // bitmap, set bit means free
   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

   logic [FW_W-1:0]      first_word_ff;
   logic [NODE_W-1:0]    own_node_ff;
   logic [AW-1:0]        rover_ff, rover_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [AW-1:0]        count_ff, count_in;
   logic                 foreign_ff;
   logic [ID_W-1:0]      free_id_ff;
   logic [ID_W-1:0]      quot_ff, quot_in;
   logic [BW-1:0]        bit_ff, bit_in;
   logic [WORD_BITS-1:0] mem_rd_ff;
   logic [ID_W-1:0]      res_ident_ff, res_ident_in;
   status_type           res_status_ff, res_status_in;
   logic                 out_valid_ff;
   logic [ID_W-1:0]      out_ident_ff;
   status_type           out_status_ff;

   logic [AW-1:0]        wrap_tgt, adv_addr, adv_rover;
   logic [WORD_BITS-1:0] low_onehot, cleared, bit_mask;
   logic [BW-1:0]        low_idx;
   logic [PROD_W-1:0]    prod;
   logic [ID_W-1:0]      rem;
   logic [ID_W-1:0]      ident_calc;
   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [WORD_BITS-1:0] wr_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_word_ff <= FIRST_WORD_RESET;
         own_node_ff   <= OWN_NODE_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FIRST_WORD: first_word_ff <= csr_wdata[FW_W-1:0];
            CSR_OWN_NODE:   own_node_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // rover advance with wrap to the first word
   assign wrap_tgt  = (32'(first_word_ff) < 32'(MAP_WORDS)) ? AW'(first_word_ff) : '0;
   assign adv_addr  = (addr_ff == LAST_WORD) ? wrap_tgt : addr_ff + 1'b1;
   assign adv_rover = (rover_ff == LAST_WORD) ? wrap_tgt : rover_ff + 1'b1;

   // lowest free bit of the word just read
   assign low_onehot = mem_rd_ff & (~mem_rd_ff + WORD_ONE);
   assign cleared    = mem_rd_ff & (mem_rd_ff - WORD_ONE);

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (low_onehot[i]) begin
            low_idx = low_idx | BW'(i);
         end
      end
   end

   assign ident_calc = ID_W'(addr_ff) * ID_W'(WORD_BITS) + ID_W'(low_idx);

   // free id split into word and bit
   assign prod     = PROD_W'(req_free_id) * PROD_W'(DIV_MUL);
   assign quot_in  = ID_W'(prod >> DIV_SH);
   assign rem      = free_id_ff - ID_W'(quot_ff * ID_W'(WORD_BITS));
   assign bit_in   = BW'(rem);
   assign bit_mask = WORD_ONE << bit_ff;

   // memory port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '1;
      rd_en   = 1'b0;
      rd_addr = adv_addr;
      if (cmd.init_wr) begin
         wr_en = 1'b1;
      end
      if (cmd.alloc_take) begin
         wr_en   = 1'b1;
         wr_data = cleared;
      end
      if (cmd.free_set) begin
         wr_en   = 1'b1;
         wr_addr = quot_ff[AW-1:0];
         wr_data = mem_rd_ff | bit_mask;
      end
      if (cmd.accept) begin
         rd_en   = 1'b1;
         rd_addr = rover_ff;
      end
      if (cmd.srch_step || cmd.alloc_take) begin
         rd_en = 1'b1;
      end
      if (cmd.free_decode) begin
         rd_en   = 1'b1;
         rd_addr = quot_ff[AW-1:0];
      end
      if (cmd.free_set) begin
         rd_en   = 1'b1;
         rd_addr = adv_rover;
      end
   end

   // bitmap memory, a read of the word being written sees the new value
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff <= (wr_en && (wr_addr == rd_addr)) ? wr_data : map_mem[rd_addr];
      end
   end

   // search pointer, step count and rover
   always_comb begin
      addr_in  = addr_ff;
      count_in = count_ff;
      rover_in = rover_ff;
      if (cmd.init_wr) begin
         addr_in = addr_ff + 1'b1;
      end
      if (cmd.accept) begin
         addr_in  = rover_ff;
         count_in = '0;
      end
      if (cmd.srch_step) begin
         addr_in  = adv_addr;
         count_in = count_ff + 1'b1;
      end
      if (cmd.alloc_take) begin
         addr_in  = adv_addr;
         count_in = AW'(1);
         rover_in = addr_ff;
      end
      if (cmd.free_set) begin
         addr_in  = adv_rover;
         count_in = '0;
      end
      if (cmd.rover_set) begin
         rover_in = addr_ff;
      end
   end

   // result of the item at work
   always_comb begin
      res_ident_in  = res_ident_ff;
      res_status_in = res_status_ff;
      if (cmd.alloc_take) begin
         res_ident_in  = ident_calc;
         res_status_in = STAT_OK;
      end
      if (cmd.alloc_fail) begin
         res_ident_in  = '0;
         res_status_in = STAT_EXHAUSTED;
      end
      if (cmd.free_decode) begin
         res_ident_in  = '0;
         res_status_in = foreign_ff ? STAT_FOREIGN : STAT_OK;
      end
      if (cmd.free_dup) begin
         res_status_in = STAT_DOUBLE_FREE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         rover_ff     <= AW'(FIRST_WORD_RESET);
         out_valid_ff <= 1'b0;
      end else begin
         addr_ff  <= addr_in;
         rover_ff <= rover_in;
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      res_ident_ff  <= res_ident_in;
      res_status_ff <= res_status_in;
      if (cmd.accept) begin
         foreign_ff <= (req_free_node != own_node_ff);
         free_id_ff <= req_free_id;
         quot_ff    <= quot_in;
      end
      if (cmd.free_decode) begin
         bit_ff <= bit_in;
      end
      if (cmd.load_out) begin
         out_ident_ff  <= res_ident_ff;
         out_status_ff <= res_status_ff;
      end
   end

   // status to the controller
   always_comb begin
      stat.init_last       = (addr_ff == LAST_WORD);
      stat.word_nonzero    = |mem_rd_ff;
      stat.search_last     = (count_ff == LAST_WORD);
      stat.cleared_nonzero = |cleared;
      stat.foreign         = foreign_ff;
      stat.in_range        = (32'(quot_ff) < 32'(MAP_WORDS));
      stat.bit_set         = |(mem_rd_ff & bit_mask);
      stat.on_rover        = (quot_ff[AW-1:0] == rover_ff);
      stat.out_free        = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_ident  = out_ident_ff;
   assign rsp_status = out_status_ff;

endmodule

`default_nettype wire

// ----- hdl/bitmap_id_allocator_core.sv -----
// top level of the next-fit bitmap identifier allocator
//
//   channel  dir  handshake         payload
//   req_ch   in   valid / ready     kind, free_node, free_id
//   rsp_ch   out  valid / ready     ident, status
//   csr_*    in   csr_we            csr_index, csr_wdata
//
// an allocate takes the lowest free bit of the first word with one, from the rover on;
// if that word is left with no free bit, a scan of up to MAP_WORDS words moves the rover.
// a free of another node's id or of one beyond the map ends at the decode; any other free
// checks the bit and sets it if clear, plus the same scan when the freed word is under the rover.
// the scan is limited by the single read port of the bitmap memory, one word a cycle.
// after reset a clearing pass writes all MAP_WORDS words of the map; req_ch.ready stays low.
// a result waits in the output register; a stalled rsp_ch holds the next item in done.
`default_nettype none

module bitmap_id_allocator_core import bia_pkg::*; #(
   parameter int MAP_WORDS = 256,
   parameter int WORD_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   bia_req_if.sink                    req_ch,
   bia_rsp_if.source                  rsp_ch
);

   bia_cmd_type  cmd;
   bia_stat_type stat;

   // controller
   bia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   bia_datapath #(
      .MAP_WORDS (MAP_WORDS),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_free_node (req_ch.free_node),
      .req_free_id   (req_ch.free_id),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_ident     (rsp_ch.ident),
      .rsp_status    (rsp_ch.status),
      .cmd           (cmd),
      .stat          (stat)
   );

   // result register is loaded only when its slot is free
   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result loaded over an item not yet taken");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("new item taken while one is at work");

   // no item right after reset, at the start of the clearing pass
   a_clear_pass: assert property (@(posedge clock)
      $past(reset) |-> !req_ch.ready)
      else $error("item taken before the map is cleared");

endmodule

`default_nettype wire

// ----- sim/bitmap_id_allocator_core_tb.sv -----
// testbench of the bitmap id allocator core: free map tracker class and top module
`timescale 1ns / 100ps

module bitmap_id_allocator_core_tb import bia_pkg::*; ();

   localparam int     MAP_WORDS = 256;
   localparam int     WORD_BITS = 32;
   localparam int     SEGMENTS  = 3;
   localparam int     SEG_ITEMS = 20;
   localparam longint LIMIT_NS  = 64'd30_000_000;

   // mirror of the free map and roving word, queues the result each request should bring
   class id_pool_tracker;

      typedef struct packed {
         logic [ID_W-1:0] ident;
         status_type      status;
      } outcome_type;

      logic [WORD_BITS-1:0] free_map [MAP_WORDS];
      int                   roving_word;
      logic [FW_W-1:0]      first_word;
      logic [NODE_W-1:0]    own_node;
      outcome_type          due_results [$];
      logic [ID_W-1:0]      handed_ids [$];

      int granted;
      int refused;
      int returned;
      int double_freed;
      int foreign_freed;
      int reg_writes;
      int results_seen;
      int mismatches;

      function new();
         foreach (free_map[i]) free_map[i] = '1;
         first_word  = FIRST_WORD_RESET;
         own_node    = OWN_NODE_RESET;
         roving_word = (int'(first_word) < MAP_WORDS) ? int'(first_word) : 0;
      endfunction

      function int wrap_word();
         return (int'(first_word) < MAP_WORDS) ? int'(first_word) : 0;
      endfunction

      function int step_word(int w);
         return (w + 1 >= MAP_WORDS) ? wrap_word() : w + 1;
      endfunction

      // bounded walk from start to the first word that still has a free bit
      function bit find_free_word(int start, output int hit);
         int w;
         int i;
         w   = start;
         hit = start;
         for (i = 0; i < MAP_WORDS; i++) begin
            if (free_map[w] != '0) begin
               hit = w;
               return 1'b1;
            end
            w = step_word(w);
         end
         return 1'b0;
      endfunction

      function void write_reg(csr_index_type index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_FIRST_WORD) first_word = data[FW_W-1:0];
         else own_node = data[NODE_W-1:0];
         reg_writes++;
      endfunction

      // work out the result of one accepted request and update the map
      function void book_request(logic kind, logic [NODE_W-1:0] node, logic [ID_W-1:0] id);
         outcome_type want;
         int          hit;
         int          w;
         int          b;
         want.ident  = '0;
         want.status = STAT_OK;
         if (kind == KIND_ALLOC) begin
            if (!find_free_word(roving_word, hit)) begin
               want.status = STAT_EXHAUSTED;
               refused++;
            end else begin
               roving_word = hit;
               b = 0;
               while (!free_map[hit][b]) b++;
               free_map[hit][b] = 1'b0;
               want.ident = ID_W'(hit * WORD_BITS + b);
               handed_ids.push_back(want.ident);
               granted++;
               // stay on the word while it has room, otherwise move on
               if (find_free_word(roving_word, hit)) roving_word = hit;
            end
         end else if (node != own_node) begin
            want.status = STAT_FOREIGN;
            foreign_freed++;
         end else begin
            w = int'(id) / WORD_BITS;
            b = int'(id) % WORD_BITS;
            if (w < MAP_WORDS) begin
               if (free_map[w][b]) begin
                  want.status = STAT_DOUBLE_FREE;
                  double_freed++;
               end else begin
                  free_map[w][b] = 1'b1;
                  returned++;
                  // freeing under the roving word pushes it past that word
                  if (w == roving_word) begin
                     if (find_free_word(step_word(roving_word), hit)) roving_word = hit;
                  end
               end
            end
         end
         due_results.push_back(want);
      endfunction

      // compare one accepted result with the oldest one due
      function void check_result(logic [ID_W-1:0] ident, logic [STATUS_W-1:0] status);
         outcome_type want;
         results_seen++;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with nothing due: ident %0d status %0d",
                        $realtime, ident, status);
            return;
         end
         want = due_results.pop_front();
         if (ident !== want.ident || status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result %0d: expected ident %0d status %0d, got %0d %0d",
                        $realtime, results_seen, want.ident, want.status, ident, status);
         end
      endfunction

   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bia_req_if req_ch ();
   bia_rsp_if rsp_ch ();

   id_pool_tracker pool = new();

   int send_gap_max;
   int rsp_stall_max;

   bitmap_id_allocator_core #(
      .MAP_WORDS (MAP_WORDS),
      .WORD_BITS (WORD_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // 50 MHz clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // choose how hard each side idles for the next stretch
   function automatic void pick_pace();
      case ($urandom_range(0, 3))
         0: begin
            send_gap_max  = 0;
            rsp_stall_max = 0;
         end
         1: begin
            send_gap_max  = 16;
            rsp_stall_max = 0;
         end
         2: begin
            send_gap_max  = 0;
            rsp_stall_max = 16;
         end
         default: begin
            send_gap_max  = 16;
            rsp_stall_max = 16;
         end
      endcase
   endfunction

   // present one item after a random gap, hold it until taken, then predict its result
   task automatic send_item(logic kind, logic [NODE_W-1:0] node, logic [ID_W-1:0] id);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= kind;
      req_ch.free_node <= node;
      req_ch.free_id   <= id;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      pool.book_request(kind, node, id);
   endtask

   // allocate with junk in the fields the block ignores
   task automatic alloc_one();
      send_item(KIND_ALLOC, NODE_W'($urandom), ID_W'($urandom));
   endtask

   task automatic free_own(logic [ID_W-1:0] id);
      send_item(KIND_FREE, pool.own_node, id);
   endtask

   task automatic free_foreign();
      logic [NODE_W-1:0] node;
      node = NODE_W'($urandom);
      if (node == pool.own_node) node = ~node;
      send_item(KIND_FREE, node, ID_W'($urandom));
   endtask

   // stop sending and wait until every result has come back
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pool.due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      pool.write_reg(index, data);
   endtask

   // pull a handed out id whose word lies in the given range
   function automatic bit take_held(int lo_word, int hi_word, output logic [ID_W-1:0] id);
      int n;
      int start;
      int k;
      int pos;
      int w;
      id = '0;
      n  = pool.handed_ids.size();
      if (n == 0) return 1'b0;
      start = $urandom_range(0, n - 1);
      for (k = 0; k < n; k++) begin
         pos = (start + k) % n;
         w   = int'(pool.handed_ids[pos]) / WORD_BITS;
         if (w >= lo_word && w <= hi_word) begin
            id = pool.handed_ids[pos];
            pool.handed_ids.delete(pos);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // result side: random stalls on ready, every accepted item goes to the checker
   initial begin : result_sink
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);
         pool.check_result(rsp_ch.ident, rsp_ch.status);
      end
   end

   // hang guard
   initial begin : watchdog
      #(LIMIT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [ID_W-1:0] id;
      int              sel;
      int              seg;
      int              n;
      req_ch.valid     = 1'b0;
      req_ch.kind      = KIND_ALLOC;
      req_ch.free_node = '0;
      req_ch.free_id   = '0;
      csr_we           = 1'b0;
      csr_index        = CSR_FIRST_WORD;
      csr_wdata        = '0;
      send_gap_max     = 0;
      rsp_stall_max    = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed items on reset settings, back to back
      alloc_one();
      send_item(KIND_ALLOC, '1, '1);
      free_own(ID_W'(0));                           // word 0 never handed out
      free_own('1);                                 // top id, still free
      send_item(KIND_FREE, '1, ID_W'(WORD_BITS));   // other node
      free_own(ID_W'(WORD_BITS + 1));               // on the roving word, moves it on
      alloc_one();
      free_own(ID_W'(WORD_BITS + 1));               // same id twice
      free_own(ID_W'(WORD_BITS));                   // behind the roving word
      send_item(KIND_ALLOC, '0, '0);
      rsp_stall_max = 16;
      free_own(ID_W'(2 * WORD_BITS + WORD_BITS - 1));
      alloc_one();
      alloc_one();
      free_own(ID_W'(2 * WORD_BITS));
      alloc_one();
      settle();
      pool.handed_ids.delete();

      // wrap onto the top word only, then walk the roving word up to it
      write_reg(CSR_FIRST_WORD, {8'($urandom), FW_W'(MAP_WORDS - 1)});
      write_reg(CSR_OWN_NODE, CSR_DATA_W'($urandom));
      n = 0;
      while (pool.roving_word != MAP_WORDS - 1) begin
         if (n % 40 == 0) pick_pace();
         if ($urandom_range(0, 99) == 0) settle();
         n++;
         alloc_one();
         sel = $urandom_range(0, 19);
         if (sel == 0) free_foreign();
         // most ids go straight back, which pushes the roving word on
         if (sel != 1 && pool.handed_ids.size() != 0) free_own(pool.handed_ids.pop_back());
      end

      // use up the top word; with the wrap on it as well the map reads as full
      while (pool.free_map[MAP_WORDS - 1] != '0) alloc_one();
      alloc_one();
      alloc_one();
      // a word below the wrap target is out of reach of the search
      if (take_held(0, MAP_WORDS - 2, id)) free_own(id);
      alloc_one();
      // a free on the roving word opens it again
      if (take_held(MAP_WORDS - 1, MAP_WORDS - 1, id)) free_own(id);
      alloc_one();
      alloc_one();
      // moving the wrap target leaves the roving word where it is
      settle();
      write_reg(CSR_FIRST_WORD, {8'($urandom), FW_W'(0)});
      alloc_one();
      alloc_one();

      // mixed traffic under several settings
      for (seg = 0; seg < SEGMENTS; seg++) begin
         settle();
         write_reg(CSR_FIRST_WORD, CSR_DATA_W'($urandom));
         case (seg)
            0: write_reg(CSR_OWN_NODE, '1);
            1: write_reg(CSR_OWN_NODE, '0);
            default: write_reg(CSR_OWN_NODE, CSR_DATA_W'($urandom));
         endcase
         send_item(KIND_FREE, ~pool.own_node, '1);
         for (n = 0; n < SEG_ITEMS; n++) begin
            if (n % 20 == 0) pick_pace();
            if ($urandom_range(0, 49) == 0) settle();
            sel = $urandom_range(0, 99);
            if (sel < 45 || pool.handed_ids.size() == 0) begin
               alloc_one();
            end else if (sel < 75) begin
               if (take_held(0, MAP_WORDS - 1, id)) free_own(id);
            end else if (sel < 87) begin
               free_own(ID_W'($urandom));
            end else begin
               free_foreign();
            end
         end
      end

      // drain and watch for stray results
      settle();
      repeat (MAP_WORDS + 16) @(posedge clock);
      $display("covered %0d ids granted, %0d refused on a full map, %0d returned to the map",
               pool.granted, pool.refused, pool.returned);
      $display("plus %0d double frees, %0d other-node frees, %0d register writes",
               pool.double_freed, pool.foreign_freed, pool.reg_writes);
      $display("%0d results checked, %0d bad", pool.results_seen, pool.mismatches);
      if (pool.mismatches == 0 && pool.due_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- bitmap_id_allocator_core.f -----
hdl/bia_pkg.sv
hdl/bia_if.sv
hdl/bia_ctrl.sv
hdl/bia_datapath.sv
hdl/bitmap_id_allocator_core.sv
sim/bitmap_id_allocator_core_tb.sv
